/* hw/rtl/isba_pkg.sv */
package isba_pkg;

   localparam int SLOTS   = 64;
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;
   localparam int CODE_W  = 3;
   localparam int STAT_W  = 3;
   localparam int FIND_W  = 64;
   localparam int GROUP_W = 8;

   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [STAT_W-1:0]  status_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [SLOTS-1:0]   map_type;

   localparam code_type OP_FIND_FREE       = 3'd0;
   localparam code_type OP_MARK_USED       = 3'd1;
   localparam code_type OP_INSERT_UNSTABLE = 3'd2;
   localparam code_type OP_ERASE_UNSTABLE  = 3'd3;
   localparam code_type OP_LOOKUP          = 3'd4;
   localparam code_type OP_CLAIM_BUILDING  = 3'd5;
   localparam code_type OP_RELEASE         = 3'd6;
   localparam code_type OP_CLEAR_ALL       = 3'd7;

   localparam code_type RC_OK        = 3'd0;
   localparam code_type RC_INVALID   = 3'd1;
   localparam code_type RC_DUPLICATE = 3'd2;
   localparam code_type RC_IN_USE    = 3'd3;
   localparam code_type RC_NOT_FOUND = 3'd4;

   localparam status_type ST_BUILDING = 3'd2;

   localparam count_type SLOT_LIMIT = COUNT_W'(SLOTS);

   // Lowest set bit of a 64-bit word, found per group of eight and then within the group.
   function automatic slot_type find_first(input logic [FIND_W-1:0] v);
      logic [GROUP_W-1:0] grp;
      logic [GROUP_W-1:0] sel;
      logic [2:0]         g;
      logic [2:0]         b;
      for (int j = 0; j < GROUP_W; j++) begin
         grp[j] = |v[j*GROUP_W +: GROUP_W];
      end
      g = '0;
      for (int j = GROUP_W - 1; j >= 0; j--) begin
         if (grp[j]) begin
            g = 3'(j);
         end
      end
      sel = v[{g, 3'b000} +: GROUP_W];
      b = '0;
      for (int j = GROUP_W - 1; j >= 0; j--) begin
         if (sel[j]) begin
            b = 3'(j);
         end
      end
      return {g, b};
   endfunction

endpackage

/* hw/rtl/index_slot_bitmap_allocator.sv */
// Slot allocator over 64 index slots with unique and non-unique occupancy bitmaps and a set of
// unstable entries, each with a stored status and unique flag. One request beat is accepted in
// every cycle while the response register is empty or its beat is being taken. Taking a beat
// registers the request and reads the status memory; the operation is then applied to the
// bitmaps and counters and the response is registered. That update of the bitmaps, the running
// used and unstable counters and the lowest-free-slot encoder sets the rate of one beat per
// cycle. A status written by one beat is forwarded to a lookup that follows it directly. The
// status memory is not cleared; an entry is read only after it was inserted.
module index_slot_bitmap_allocator
   import isba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  code_type   req_op,
   input  slot_type   req_slot,
   input  logic       req_is_unique,
   input  status_type req_entry_status,
   input  logic       req_obj_valid,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output code_type   rsp_result_code,
   output slot_type   rsp_free_slot,
   output logic       rsp_free_found,
   output logic       rsp_entry_hit,
   output status_type rsp_hit_status,
   output count_type  rsp_used_count,
   output count_type  rsp_normal_count
);

   logic       in_valid_ff;
   code_type   in_op_ff;
   slot_type   in_slot_ff;
   logic       in_uniq_ff;
   status_type in_status_ff;
   logic       in_objv_ff;

   map_type   uniq_bits_ff, uniq_bits_in;
   map_type   nonuniq_bits_ff, nonuniq_bits_in;
   map_type   unst_bits_ff, unst_bits_in;
   map_type   unst_uniq_ff, unst_uniq_in;
   count_type used_ff, used_in;
   count_type unst_ff, unst_in;

   logic       fwd_hit_ff;
   status_type fwd_data_ff;

   logic       rsp_valid_ff;
   code_type   rsp_code_ff, rsp_code_in;
   slot_type   rsp_fslot_ff, rsp_fslot_in;
   logic       rsp_ffound_ff, rsp_ffound_in;
   logic       rsp_ehit_ff, rsp_ehit_in;
   status_type rsp_hstat_ff, rsp_hstat_in;
   count_type  rsp_used_ff;
   count_type  rsp_normal_ff, rsp_normal_in;

   logic       accept;
   logic       ex_go;
   logic       slot_ok;
   map_type    one_bit;
   map_type    sel_bit;
   map_type    used_map;
   map_type    free_map;
   logic       hit;
   logic       used_at;
   logic       used_inc;
   logic       used_dec;
   logic       unst_inc;
   logic       unst_dec;
   logic       clear_all;
   logic       ram_we;
   status_type wr_data;
   status_type ram_rd;
   status_type stored_status;

   assign ex_go     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || ex_go;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (accept) begin
         in_op_ff     <= req_op;
         in_slot_ff   <= req_slot;
         in_uniq_ff   <= req_is_unique;
         in_status_ff <= req_entry_status;
         in_objv_ff   <= req_obj_valid;
      end
   end

   // Status memory: read when the request beat is taken, written when an entry is created.
   isba_ram #(
      .WIDTH(STAT_W),
      .DEPTH(SLOTS)
   ) u_status_ram (
      .clock  (clock),
      .wr_en  (ex_go && ram_we),
      .wr_addr(in_slot_ff[SLOT_AW-1:0]),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(req_slot[SLOT_AW-1:0]),
      .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (accept) begin
         fwd_hit_ff <= ex_go && ram_we
                       && (in_slot_ff[SLOT_AW-1:0] == req_slot[SLOT_AW-1:0]);
      end
      if (accept) begin
         fwd_data_ff <= wr_data;
      end
   end

   assign stored_status = fwd_hit_ff ? fwd_data_ff : ram_rd;

   assign one_bit  = {{(SLOTS-1){1'b0}}, 1'b1};
   assign slot_ok  = {1'b0, in_slot_ff} < SLOT_LIMIT;
   assign sel_bit  = slot_ok ? (one_bit << in_slot_ff) : '0;
   assign used_map = uniq_bits_ff | nonuniq_bits_ff;
   assign free_map = ~used_map;
   assign hit      = |(unst_bits_ff & sel_bit);
   assign used_at  = |(used_map & sel_bit);
   assign wr_data  = (in_op_ff == OP_CLAIM_BUILDING) ? ST_BUILDING : in_status_ff;

   always_comb begin
      rsp_code_in     = RC_OK;
      rsp_fslot_in    = '0;
      rsp_ffound_in   = 1'b0;
      rsp_ehit_in     = 1'b0;
      rsp_hstat_in    = '0;
      uniq_bits_in    = uniq_bits_ff;
      nonuniq_bits_in = nonuniq_bits_ff;
      unst_bits_in    = unst_bits_ff;
      unst_uniq_in    = unst_uniq_ff;
      used_inc        = 1'b0;
      used_dec        = 1'b0;
      unst_inc        = 1'b0;
      unst_dec        = 1'b0;
      clear_all       = 1'b0;
      ram_we          = 1'b0;
      if (in_op_ff != OP_FIND_FREE && in_op_ff != OP_CLEAR_ALL && !slot_ok) begin
         rsp_code_in = RC_INVALID;
      end else begin
         case (in_op_ff)
            OP_FIND_FREE: begin
               if (free_map == '0) begin
                  rsp_code_in = RC_NOT_FOUND;
               end else begin
                  rsp_fslot_in  = find_first(FIND_W'(free_map));
                  rsp_ffound_in = 1'b1;
               end
            end
            OP_MARK_USED: begin
               used_inc = !used_at;
               if (in_uniq_ff) begin
                  uniq_bits_in = uniq_bits_ff | sel_bit;
               end else begin
                  nonuniq_bits_in = nonuniq_bits_ff | sel_bit;
               end
            end
            OP_INSERT_UNSTABLE, OP_CLAIM_BUILDING: begin
               if (!in_objv_ff
                   || (in_op_ff == OP_INSERT_UNSTABLE && in_status_ff < ST_BUILDING)) begin
                  rsp_code_in = RC_INVALID;
               end else if (in_op_ff == OP_CLAIM_BUILDING && used_at) begin
                  rsp_code_in = RC_IN_USE;
               end else if (hit) begin
                  rsp_code_in = RC_DUPLICATE;
               end else begin
                  ram_we       = 1'b1;
                  unst_inc     = 1'b1;
                  unst_bits_in = unst_bits_ff | sel_bit;
                  unst_uniq_in = in_uniq_ff ? (unst_uniq_ff | sel_bit)
                                            : (unst_uniq_ff & ~sel_bit);
                  if (in_op_ff == OP_CLAIM_BUILDING) begin
                     used_inc = 1'b1;
                     if (in_uniq_ff) begin
                        uniq_bits_in = uniq_bits_ff | sel_bit;
                     end else begin
                        nonuniq_bits_in = nonuniq_bits_ff | sel_bit;
                     end
                  end
               end
            end
            OP_ERASE_UNSTABLE, OP_LOOKUP, OP_RELEASE: begin
               if (!hit) begin
                  rsp_code_in = RC_NOT_FOUND;
               end else if (in_op_ff == OP_LOOKUP) begin
                  rsp_ehit_in  = 1'b1;
                  rsp_hstat_in = stored_status;
               end else begin
                  rsp_ehit_in  = 1'b1;
                  unst_dec     = 1'b1;
                  unst_bits_in = unst_bits_ff & ~sel_bit;
                  unst_uniq_in = unst_uniq_ff & ~sel_bit;
                  if (in_op_ff == OP_RELEASE) begin
                     if (|(unst_uniq_ff & sel_bit)) begin
                        uniq_bits_in = uniq_bits_ff & ~sel_bit;
                        used_dec     = |(uniq_bits_ff & sel_bit)
                                       && !(|(nonuniq_bits_ff & sel_bit));
                     end else begin
                        nonuniq_bits_in = nonuniq_bits_ff & ~sel_bit;
                        used_dec        = |(nonuniq_bits_ff & sel_bit)
                                          && !(|(uniq_bits_ff & sel_bit));
                     end
                  end
               end
            end
            OP_CLEAR_ALL: begin
               clear_all = 1'b1;
            end
            default: begin
               rsp_code_in = RC_INVALID;
            end
         endcase
      end
      if (clear_all) begin
         uniq_bits_in    = '0;
         nonuniq_bits_in = '0;
         unst_bits_in    = '0;
         unst_uniq_in    = '0;
         used_in         = '0;
         unst_in         = '0;
      end else begin
         used_in = used_ff + COUNT_W'(used_inc) - COUNT_W'(used_dec);
         unst_in = unst_ff + COUNT_W'(unst_inc) - COUNT_W'(unst_dec);
      end
      rsp_normal_in = (used_in > unst_in) ? (used_in - unst_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uniq_bits_ff    <= '0;
         nonuniq_bits_ff <= '0;
         unst_bits_ff    <= '0;
         unst_uniq_ff    <= '0;
         used_ff         <= '0;
         unst_ff         <= '0;
      end else if (ex_go) begin
         uniq_bits_ff    <= uniq_bits_in;
         nonuniq_bits_ff <= nonuniq_bits_in;
         unst_bits_ff    <= unst_bits_in;
         unst_uniq_ff    <= unst_uniq_in;
         used_ff         <= used_in;
         unst_ff         <= unst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ex_go) begin
         rsp_code_ff   <= rsp_code_in;
         rsp_fslot_ff  <= rsp_fslot_in;
         rsp_ffound_ff <= rsp_ffound_in;
         rsp_ehit_ff   <= rsp_ehit_in;
         rsp_hstat_ff  <= rsp_hstat_in;
         rsp_used_ff   <= used_in;
         rsp_normal_ff <= rsp_normal_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_code  = rsp_code_ff;
   assign rsp_free_slot    = rsp_fslot_ff;
   assign rsp_free_found   = rsp_ffound_ff;
   assign rsp_entry_hit    = rsp_ehit_ff;
   assign rsp_hit_status   = rsp_hstat_ff;
   assign rsp_used_count   = rsp_used_ff;
   assign rsp_normal_count = rsp_normal_ff;

   a_used_count: assert property (@(posedge clock) disable iff (reset)
      used_ff == COUNT_W'($countones(uniq_bits_ff | nonuniq_bits_ff)))
      else $error("used counter disagrees with the occupancy bitmaps");

   a_unstable_count: assert property (@(posedge clock) disable iff (reset)
      unst_ff == COUNT_W'($countones(unst_bits_ff)))
      else $error("unstable counter disagrees with the entry bitmap");

   a_unique_flag: assert property (@(posedge clock) disable iff (reset)
      (unst_uniq_ff & ~unst_bits_ff) == '0)
      else $error("unique flag set for a slot without an entry");

   a_normal_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_normal_ff <= rsp_used_ff)
      else $error("normal count exceeds used count");

endmodule

/* hw/rtl/isba_ram.sv */
module isba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
